FILE: rtl/core/vrlp_vita_packet_deframer_assert.svh
// Assertion macros for the VRLP deframer.
// Used by vrlp_vita_packet_deframer.sv; expects clk and rst_n in scope.
`ifndef VRLP_VITA_PACKET_DEFRAMER_ASSERT_SVH
`define VRLP_VITA_PACKET_DEFRAMER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition implies consequence in the same cycle
`define VRLPDF_ASSERT_IMPLY(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// condition implies consequence in the next cycle
`define VRLPDF_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define VRLPDF_ASSERT_IMPLY(label, cond, cons, msg)
`define VRLPDF_ASSERT_NEXT(label, cond, cons, msg)
`endif
`endif

FILE: rtl/core/vrlpdf_pkg.sv
// Shared types and constants of the VRLP deframer.
// No dependencies.
`default_nettype none
package vrlpdf_pkg;
    localparam logic [31:0] MARK_VRLP = 32'h5652_4C50;
    localparam logic [31:0] MARK_VEND = 32'h5645_4E44;
    localparam int HDR_TSF_BIT = 20;
    localparam int HDR_SID_BIT = 28;
    localparam int HDR_EXT_BIT = 29;
    localparam logic [31:0] HDR_BLANK = (32'd1 << 30) | (32'd1 << 27) | (32'd1 << 26)
                                      | (32'd1 << 23) | (32'd1 << 22);
    localparam int MAX_RESULTS = 64;

    localparam logic [1:0] REG_RECOVER_MODE = 2'd0;
    localparam logic [1:0] REG_NUM_OUTPUTS  = 2'd1;

    localparam logic [1:0] STATUS_PAYLOAD = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROP    = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_TAG  = 2'd1;
    localparam logic [1:0] KIND_MSG  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_R_CHECK,
        ST_R_W0,
        ST_R_W1,
        ST_R_WE,
        ST_U_W0,
        ST_U_W1,
        ST_U_W2,
        ST_U_WE,
        ST_U_W3,
        ST_U_TS0,
        ST_U_TS1,
        ST_U_PAY,
        ST_U_EMPTY,
        ST_DROP,
        ST_FIN
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/core/vrlp_vita_packet_deframer.sv
// VRLP/VITA packet deframer: byte store, frame search and payload unpacking.
// Depends on vrlpdf_pkg and vrlp_vita_packet_deframer_assert.svh.
//
// Usage:
//  - Byte channel (data_byte, end_of_buffer; byte_valid/byte_stall): one stream
//    byte per transaction. byte_stall is high while the block works on the
//    store; in plain mode a byte mid-buffer is taken each cycle.
//  - Result channel (status .. last; res_valid/res_stall): one payload word, an
//    empty-packet marker or a drop marker per transaction, last on the final one.
//    A single output register holds a result while the receiver stalls; the
//    sequencer waits on it before loading the next one.
//  - Config channel (cfg_index, cfg_data; cfg_valid/cfg_ready): ready only while
//    idle. Writing recover_mode empties the store.
// Timing: every store word is fetched over the single byte-wide read port of
// the store memory, one byte per cycle, then a registered read and an
// evaluation step. A packet is read as header words, trailer, optional
// timestamp and payload; a recover-mode slide checks each byte position.
// Reset: store empty, plain mode, num_outputs = 1, no result pending. The
// store memory itself is not cleared; it is only read where written.
`default_nettype none
module vrlp_vita_packet_deframer #(
    parameter int MAX_PACKET_BYTES = 256,
    parameter int MIN_PACKET_BYTES = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_buffer,
    // results
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       status,
    output logic [31:0]      stream_id,
    output logic [11:0]      sequence_res,
    output logic [1:0]       kind,
    output logic             has_timestamp,
    output logic [63:0]      timestamp,
    output logic [31:0]      payload_word,
    output logic             last,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int AW  = $clog2(MAX_PACKET_BYTES);      // store address
    localparam int SW  = AW + 2;                        // address sum
    localparam int CW  = $clog2(MAX_PACKET_BYTES + 1);  // fill count
    localparam int PWW = $clog2(MAX_PACKET_BYTES / 4 + 1); // frame words

    // circular address: s is below twice the store size
    function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s >= SW'(MAX_PACKET_BYTES)) ? s - SW'(MAX_PACKET_BYTES) : s;
        return r[AW-1:0];
    endfunction

    vrlpdf_pkg::state_t state_reg, state_next;

    logic [7:0]     byte_store [MAX_PACKET_BYTES];
    logic [7:0]     mem_rd_reg;
    logic           wr_en;
    logic [AW-1:0]  wr_addr, rd_addr;

    logic [CW-1:0]  fill_reg, fill_next;
    logic [AW-1:0]  start_reg, start_next;
    logic           ovf_reg, ovf_next;
    logic           recover_reg, recover_next;
    logic [7:0]     nout_reg, nout_next;

    logic [2:0]     fcnt_reg, fcnt_next;
    logic [PWW-1:0] widx_reg, widx_next;
    logic [31:0]    word_reg, word_next;
    logic [PWW-1:0] pw_reg, pw_next;
    logic [11:0]    seq_reg, seq_next;
    logic           tsf_reg, tsf_next;
    logic           ext_reg, ext_next;
    logic [31:0]    sid_reg, sid_next;
    logic [63:0]    ts_reg, ts_next;

    logic           res_valid_reg, res_valid_next;
    logic [1:0]     status_reg, status_next;
    logic [31:0]    sid_out_reg, sid_out_next;
    logic [11:0]    seq_out_reg, seq_out_next;
    logic [1:0]     kind_reg, kind_next;
    logic           hts_reg, hts_next;
    logic [63:0]    ts_out_reg, ts_out_next;
    logic [31:0]    pay_reg, pay_next;
    logic           last_reg, last_next;

    logic           fdone, res_free, byte_acc, cfg_acc;
    logic [CW-1:0]  fill_inc;
    logic           ovf_inc;
    logic [19:0]    pw_word;
    logic [2:0]     hw;
    logic [PWW+1:0] plen;

    assign fdone    = (fcnt_reg == 3'd5);
    assign res_free = !res_valid_reg || !res_stall;
    assign byte_acc = byte_valid && !byte_stall;
    assign cfg_acc  = cfg_valid && cfg_ready;
    assign fill_inc = (fill_reg < CW'(MAX_PACKET_BYTES)) ? fill_reg + 1'b1 : fill_reg;
    assign ovf_inc  = ovf_reg || (fill_reg == CW'(MAX_PACKET_BYTES));
    assign pw_word  = word_reg[19:0];
    assign hw       = tsf_reg ? 3'd6 : 3'd4;
    assign plen     = {pw_reg, 2'b00};

    // store memory: one write port, one registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            byte_store[wr_addr] <= data_byte;
        end
        mem_rd_reg <= byte_store[rd_addr];
    end

    // handshakes and memory addresses
    always_comb begin
        byte_stall = (state_reg != vrlpdf_pkg::ST_IDLE);
        cfg_ready  = (state_reg == vrlpdf_pkg::ST_IDLE);
        wr_en      = byte_acc && (fill_reg < CW'(MAX_PACKET_BYTES));
        wr_addr    = wrap_addr(SW'(start_reg) + SW'(fill_reg));
        rd_addr    = wrap_addr(SW'(start_reg) + SW'({widx_reg, 2'b00})
                               + SW'(fcnt_reg[1:0]));
    end

    // sequencer and datapath next values
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        start_next     = start_reg;
        ovf_next       = ovf_reg;
        recover_next   = recover_reg;
        nout_next      = nout_reg;
        fcnt_next      = fdone ? fcnt_reg : fcnt_reg + 3'd1;
        widx_next      = widx_reg;
        word_next      = word_reg;
        pw_next        = pw_reg;
        seq_next       = seq_reg;
        tsf_next       = tsf_reg;
        ext_next       = ext_reg;
        sid_next       = sid_reg;
        ts_next        = ts_reg;
        res_valid_next = res_valid_reg && res_stall;
        status_next    = status_reg;
        sid_out_next   = sid_out_reg;
        seq_out_next   = seq_out_reg;
        kind_next      = kind_reg;
        hts_next       = hts_reg;
        ts_out_next    = ts_out_reg;
        pay_next       = pay_reg;
        last_next      = last_reg;

        if (fcnt_reg != 3'd0 && !fdone) begin
            word_next = {word_reg[23:0], mem_rd_reg};
        end

        unique case (state_reg)
            vrlpdf_pkg::ST_IDLE: begin
                fcnt_next = 3'd0;
                widx_next = '0;
                if (cfg_acc) begin
                    if (cfg_index == vrlpdf_pkg::REG_RECOVER_MODE) begin
                        recover_next = cfg_data[0];
                        fill_next    = '0;
                        start_next   = '0;
                        ovf_next     = 1'b0;
                    end else if (cfg_index == vrlpdf_pkg::REG_NUM_OUTPUTS) begin
                        nout_next = cfg_data;
                    end
                end else if (byte_acc) begin
                    fill_next = fill_inc;
                    ovf_next  = ovf_inc;
                    if (recover_reg) begin
                        state_next = vrlpdf_pkg::ST_R_CHECK;
                    end else if (end_of_buffer) begin
                        if (ovf_inc || fill_inc < CW'(8)) begin
                            state_next = vrlpdf_pkg::ST_DROP;
                        end else begin
                            state_next = vrlpdf_pkg::ST_U_W0;
                        end
                    end
                end
            end
            vrlpdf_pkg::ST_R_CHECK: begin
                fcnt_next = 3'd0;
                widx_next = '0;
                if (fill_reg < CW'(MIN_PACKET_BYTES)) begin
                    ovf_next   = 1'b0;
                    state_next = vrlpdf_pkg::ST_IDLE;
                end else begin
                    state_next = vrlpdf_pkg::ST_R_W0;
                end
            end
            vrlpdf_pkg::ST_R_W0: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    if (word_reg == vrlpdf_pkg::MARK_VRLP) begin
                        widx_next  = PWW'(1);
                        state_next = vrlpdf_pkg::ST_R_W1;
                    end else begin
                        start_next = wrap_addr(SW'(start_reg) + SW'(1));
                        fill_next  = fill_reg - 1'b1;
                        state_next = vrlpdf_pkg::ST_R_CHECK;
                    end
                end
            end
            vrlpdf_pkg::ST_R_W1: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    if (pw_word != 20'd0 && pw_word <= 20'(MAX_PACKET_BYTES / 4)) begin
                        pw_next = pw_word[PWW-1:0];
                        if (pw_word > 20'(fill_reg >> 2)) begin
                            state_next = vrlpdf_pkg::ST_IDLE;   // wait for more bytes
                        end else begin
                            widx_next  = pw_word[PWW-1:0] - 1'b1;
                            state_next = vrlpdf_pkg::ST_R_WE;
                        end
                    end else begin
                        start_next = wrap_addr(SW'(start_reg) + SW'(1));
                        fill_next  = fill_reg - 1'b1;
                        state_next = vrlpdf_pkg::ST_R_CHECK;
                    end
                end
            end
            vrlpdf_pkg::ST_R_WE: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    widx_next = '0;
                    if (word_reg == vrlpdf_pkg::MARK_VEND) begin
                        state_next = vrlpdf_pkg::ST_U_W0;
                    end else begin
                        start_next = wrap_addr(SW'(start_reg) + SW'(1));
                        fill_next  = fill_reg - 1'b1;
                        state_next = vrlpdf_pkg::ST_R_CHECK;
                    end
                end
            end
            vrlpdf_pkg::ST_U_W0: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    if (word_reg == vrlpdf_pkg::MARK_VRLP) begin
                        widx_next  = PWW'(1);
                        state_next = vrlpdf_pkg::ST_U_W1;
                    end else begin
                        state_next = vrlpdf_pkg::ST_DROP;
                    end
                end
            end
            vrlpdf_pkg::ST_U_W1: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    seq_next  = word_reg[31:20];
                    if (pw_word > 20'(fill_reg >> 2) || pw_word < 20'd5) begin
                        state_next = vrlpdf_pkg::ST_DROP;
                    end else begin
                        pw_next    = pw_word[PWW-1:0];
                        widx_next  = PWW'(2);
                        state_next = vrlpdf_pkg::ST_U_W2;
                    end
                end
            end
            vrlpdf_pkg::ST_U_W2: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    tsf_next  = word_reg[vrlpdf_pkg::HDR_TSF_BIT];
                    ext_next  = word_reg[vrlpdf_pkg::HDR_EXT_BIT];
                    ts_next   = '0;
                    if (word_reg[15:0] != 16'(pw_reg) - 16'd3
                        || word_reg[19:16] != seq_reg[3:0]
                        || !word_reg[vrlpdf_pkg::HDR_SID_BIT]
                        || (word_reg & vrlpdf_pkg::HDR_BLANK) != 32'd0
                        || pw_reg < (word_reg[vrlpdf_pkg::HDR_TSF_BIT] ? PWW'(7) : PWW'(5)))
                    begin
                        state_next = vrlpdf_pkg::ST_DROP;
                    end else begin
                        widx_next  = pw_reg - 1'b1;
                        state_next = vrlpdf_pkg::ST_U_WE;
                    end
                end
            end
            vrlpdf_pkg::ST_U_WE: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    if (word_reg == vrlpdf_pkg::MARK_VEND) begin
                        widx_next  = PWW'(3);
                        state_next = vrlpdf_pkg::ST_U_W3;
                    end else begin
                        state_next = vrlpdf_pkg::ST_DROP;
                    end
                end
            end
            vrlpdf_pkg::ST_U_W3: begin
                if (fdone) begin
                    fcnt_next = 3'd0;
                    sid_next  = word_reg;
                    widx_next = PWW'(4);
                    if (word_reg >= {24'd0, nout_reg}
                        || int'(pw_reg) > int'(hw) + 1 + vrlpdf_pkg::MAX_RESULTS) begin
                        state_next = vrlpdf_pkg::ST_DROP;
                    end else if (tsf_reg) begin
                        state_next = vrlpdf_pkg::ST_U_TS0;
                    end else if (pw_reg == PWW'(5)) begin
                        state_next = vrlpdf_pkg::ST_U_EMPTY;
                    end else begin
                        state_next = vrlpdf_pkg::ST_U_PAY;
                    end
                end
            end
            vrlpdf_pkg::ST_U_TS0: begin
                if (fdone) begin
                    fcnt_next      = 3'd0;
                    ts_next[63:32] = word_reg;
                    widx_next      = PWW'(5);
                    state_next     = vrlpdf_pkg::ST_U_TS1;
                end
            end
            vrlpdf_pkg::ST_U_TS1: begin
                if (fdone) begin
                    fcnt_next     = 3'd0;
                    ts_next[31:0] = word_reg;
                    widx_next     = PWW'(6);
                    if (pw_reg == PWW'(7)) begin
                        state_next = vrlpdf_pkg::ST_U_EMPTY;
                    end else begin
                        state_next = vrlpdf_pkg::ST_U_PAY;
                    end
                end
            end
            vrlpdf_pkg::ST_U_PAY: begin
                if (fdone && res_free) begin
                    fcnt_next      = 3'd0;
                    res_valid_next = 1'b1;
                    status_next    = vrlpdf_pkg::STATUS_PAYLOAD;
                    sid_out_next   = sid_reg;
                    seq_out_next   = seq_reg;
                    kind_next      = !ext_reg ? vrlpdf_pkg::KIND_DATA
                                   : (tsf_reg ? vrlpdf_pkg::KIND_TAG : vrlpdf_pkg::KIND_MSG);
                    hts_next       = tsf_reg;
                    ts_out_next    = ts_reg;
                    pay_next       = word_reg;
                    last_next      = (widx_reg == pw_reg - PWW'(2));
                    widx_next      = widx_reg + 1'b1;
                    if (widx_reg == pw_reg - PWW'(2)) begin
                        state_next = vrlpdf_pkg::ST_FIN;
                    end
                end
            end
            vrlpdf_pkg::ST_U_EMPTY: begin
                if (res_free) begin
                    res_valid_next = 1'b1;
                    status_next    = vrlpdf_pkg::STATUS_EMPTY;
                    sid_out_next   = sid_reg;
                    seq_out_next   = seq_reg;
                    kind_next      = !ext_reg ? vrlpdf_pkg::KIND_DATA
                                   : (tsf_reg ? vrlpdf_pkg::KIND_TAG : vrlpdf_pkg::KIND_MSG);
                    hts_next       = tsf_reg;
                    ts_out_next    = ts_reg;
                    pay_next       = '0;
                    last_next      = 1'b1;
                    state_next     = vrlpdf_pkg::ST_FIN;
                end
            end
            vrlpdf_pkg::ST_DROP: begin
                if (res_free) begin
                    res_valid_next = 1'b1;
                    status_next    = vrlpdf_pkg::STATUS_DROP;
                    sid_out_next   = '0;
                    seq_out_next   = '0;
                    kind_next      = vrlpdf_pkg::KIND_DATA;
                    hts_next       = 1'b0;
                    ts_out_next    = '0;
                    pay_next       = '0;
                    last_next      = 1'b1;
                    state_next     = vrlpdf_pkg::ST_FIN;
                end
            end
            vrlpdf_pkg::ST_FIN: begin
                // recover mode consumes the frame, plain mode empties the store
                if (recover_reg) begin
                    start_next = wrap_addr(SW'(start_reg) + SW'(plen));
                    fill_next  = fill_reg - CW'(plen);
                end else begin
                    fill_next  = '0;
                    start_next = '0;
                    ovf_next   = 1'b0;
                end
                state_next = vrlpdf_pkg::ST_IDLE;
            end
            default: begin
                state_next = vrlpdf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= vrlpdf_pkg::ST_IDLE;
            fill_reg      <= '0;
            start_reg     <= '0;
            ovf_reg       <= 1'b0;
            recover_reg   <= 1'b0;
            nout_reg      <= 8'd1;
            fcnt_reg      <= '0;
            widx_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            start_reg     <= start_next;
            ovf_reg       <= ovf_next;
            recover_reg   <= recover_next;
            nout_reg      <= nout_next;
            fcnt_reg      <= fcnt_next;
            widx_reg      <= widx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        word_reg    <= word_next;
        pw_reg      <= pw_next;
        seq_reg     <= seq_next;
        tsf_reg     <= tsf_next;
        ext_reg     <= ext_next;
        sid_reg     <= sid_next;
        ts_reg      <= ts_next;
        status_reg  <= status_next;
        sid_out_reg <= sid_out_next;
        seq_out_reg <= seq_out_next;
        kind_reg    <= kind_next;
        hts_reg     <= hts_next;
        ts_out_reg  <= ts_out_next;
        pay_reg     <= pay_next;
        last_reg    <= last_next;
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign stream_id     = sid_out_reg;
    assign sequence_res  = seq_out_reg;
    assign kind          = kind_reg;
    assign has_timestamp = hts_reg;
    assign timestamp     = ts_out_reg;
    assign payload_word  = pay_reg;
    assign last          = last_reg;

`include "vrlp_vita_packet_deframer_assert.svh"

    `VRLPDF_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_reg <= CW'(MAX_PACKET_BYTES), "fill over store size")
    `VRLPDF_ASSERT_IMPLY(a_recover_idle_room, state_reg == vrlpdf_pkg::ST_IDLE && recover_reg, fill_reg < CW'(MAX_PACKET_BYTES), "recover store full while idle")
    `VRLPDF_ASSERT_IMPLY(a_consume_bound, state_reg == vrlpdf_pkg::ST_FIN && recover_reg, CW'(plen) <= fill_reg && plen != '0, "frame consume exceeds fill")
    `VRLPDF_ASSERT_IMPLY(a_drop_shape, res_valid_reg && status_reg == vrlpdf_pkg::STATUS_DROP, last_reg && pay_reg == 32'd0 && sid_out_reg == 32'd0, "malformed drop result")
    `VRLPDF_ASSERT_NEXT(a_fin_idle, state_reg == vrlpdf_pkg::ST_FIN, state_reg == vrlpdf_pkg::ST_IDLE, "finish did not return to idle")

endmodule
`default_nettype wire
